/* design/gtm_pkg.sv */
// Shared types and constants for the outer-product MAC tile.
// No dependencies.
`default_nettype none
package gtm_pkg;
    localparam int OUT_WIDTH   = 48;
    localparam int ALPHA_WIDTH = 16;
    localparam int ALPHA_SHIFT = 8;
    localparam int CNT_WIDTH   = 4;
    localparam int IDX_WIDTH   = 3;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;

    // Controller to datapath command group
    typedef struct packed {
        logic accumulate;   // add the input step into the array
        logic clear;        // zero the array after the dump
        logic scale;        // multiply the selected accumulator by alpha
        logic [3:0] row;
        logic [3:0] col;
    } gtm_cmd_t;
endpackage
`default_nettype wire

/* design/gemm_tile_outer_product_mac_unit.sv */
// Top level: 8x8 outer-product MAC tile with row-major scaled dump.
// Steps: a step is absorbed into the accumulators; on a last step each result
// is selected and multiplied by alpha (registered), then rounded and presented.
// Throughput: 1 step per cycle while idle; a dump of R*C results waits on any
// output stall, and input steps are stalled for the whole dump.
// Reset clears control; alpha=256, rows=cols=8; the first cycle after reset
// clears the accumulators (input stalled), and each dump clears them again.
`default_nettype none
module gemm_tile_outer_product_mac_unit
    import gtm_pkg::*;
#(
    parameter int TILE_ROWS   = 8,
    parameter int TILE_COLS   = 8,
    parameter int VALUE_WIDTH = 16,
    parameter int ACC_WIDTH   = 48
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [15:0]            cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [63:0]            a_rows_low,
    input  wire logic [63:0]            a_rows_high,
    input  wire logic [63:0]            b_cols_low,
    input  wire logic [63:0]            b_cols_high,
    input  wire logic                   last_step,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [2:0]                  tile_row,
    output logic [2:0]                  tile_col,
    output logic signed [47:0]          scaled_sum,
    output logic                        last_result
);
    logic signed [ALPHA_WIDTH-1:0] alpha_reg;
    logic [CNT_WIDTH-1:0] rows_reg, cols_reg;
    logic rst_clear_reg;
    logic ctrl_valid, ctrl_stall;
    gtm_cmd_t cmd, cmd_dp;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 16'sd256;
            rows_reg <= 4'd8;
            cols_reg <= 4'd8;
            rst_clear_reg <= 1'b1;
        end
        else
        begin
            rst_clear_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ALPHA: alpha_reg <= cfg_data;
                    REG_ROWS:  rows_reg <= cfg_data[CNT_WIDTH-1:0];
                    REG_COLS:  cols_reg <= cfg_data[CNT_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Hold off input words while the array is being cleared after reset
    assign ctrl_valid = in_valid && !rst_clear_reg;
    assign in_stall   = ctrl_stall || rst_clear_reg;

    gtm_ctrl #(.TILE_ROWS(TILE_ROWS), .TILE_COLS(TILE_COLS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(ctrl_valid), .in_stall(ctrl_stall),
        .in_last(last_step), .rows_cfg(rows_reg), .cols_cfg(cols_reg), .cmd(cmd),
        .out_valid(out_valid), .out_stall(out_stall), .out_row(tile_row),
        .out_col(tile_col), .out_last(last_result)
    );

    // Clear the array in the first cycle after reset
    always_comb
    begin
        cmd_dp = cmd;
        cmd_dp.clear = cmd.clear || rst_clear_reg;
    end

    gtm_datapath #(.TILE_ROWS(TILE_ROWS), .TILE_COLS(TILE_COLS),
        .VALUE_WIDTH(VALUE_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_dp (
        .clk(clk), .cmd(cmd_dp), .a_lo(a_rows_low), .a_hi(a_rows_high),
        .b_lo(b_cols_low), .b_hi(b_cols_high), .alpha(alpha_reg), .scaled(scaled_sum)
    );
endmodule
`default_nettype wire

/* design/gtm_datapath.sv */
// Datapath: accumulator array, saturating MACs, scale and round stage.
// Depends on gtm_pkg.
`default_nettype none
module gtm_datapath
    import gtm_pkg::*;
#(
    parameter int TILE_ROWS   = 8,
    parameter int TILE_COLS   = 8,
    parameter int VALUE_WIDTH = 16,
    parameter int ACC_WIDTH   = 48
)
(
    input  wire logic                          clk,
    input  wire gtm_cmd_t                      cmd,
    input  wire logic [63:0]                   a_lo,
    input  wire logic [63:0]                   a_hi,
    input  wire logic [63:0]                   b_lo,
    input  wire logic [63:0]                   b_hi,
    input  wire logic signed [ALPHA_WIDTH-1:0] alpha,
    output logic signed [OUT_WIDTH-1:0]        scaled
);
    localparam int LANES = 64 / VALUE_WIDTH;
    localparam int PW    = ACC_WIDTH + ALPHA_WIDTH;
    localparam logic signed [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] AMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [PW-1:0] OMAX = PW'(signed'({1'b0, {(OUT_WIDTH-1){1'b1}}}));
    localparam logic signed [PW-1:0] OMIN = -OMAX - PW'(1);

    logic signed [ACC_WIDTH-1:0] acc_reg [TILE_ROWS][TILE_COLS];
    logic signed [VALUE_WIDTH-1:0] av [TILE_ROWS];
    logic signed [VALUE_WIDTH-1:0] bv [TILE_COLS];
    logic signed [ACC_WIDTH-1:0] sel;
    logic signed [PW-1:0] prod_reg, prod_next, rnd;

    // Unpack lanes; rows beyond the two words read as zero
    always_comb
    begin
        for (int r = 0; r < TILE_ROWS; r++)
        begin
            if (r < LANES) av[r] = a_lo[r*VALUE_WIDTH +: VALUE_WIDTH];
            else if (r < 2*LANES) av[r] = a_hi[(r-LANES)*VALUE_WIDTH +: VALUE_WIDTH];
            else av[r] = '0;
        end
        for (int c = 0; c < TILE_COLS; c++)
        begin
            if (c < LANES) bv[c] = b_lo[c*VALUE_WIDTH +: VALUE_WIDTH];
            else if (c < 2*LANES) bv[c] = b_hi[(c-LANES)*VALUE_WIDTH +: VALUE_WIDTH];
            else bv[c] = '0;
        end
    end

    // One saturating MAC per element
    for (genvar r = 0; r < TILE_ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < TILE_COLS; c++)
        begin : g_col
            logic signed [2*VALUE_WIDTH-1:0] p;
            logic signed [ACC_WIDTH:0] s;
            assign p = av[r] * bv[c];
            assign s = (ACC_WIDTH+1)'(acc_reg[r][c]) + (ACC_WIDTH+1)'(p);
            always_ff @(posedge clk)
            begin
                if (cmd.clear)
                    acc_reg[r][c] <= '0;
                else if (cmd.accumulate)
                begin
                    if (s > (ACC_WIDTH+1)'(AMAX)) acc_reg[r][c] <= AMAX;
                    else if (s < (ACC_WIDTH+1)'(AMIN)) acc_reg[r][c] <= AMIN;
                    else acc_reg[r][c] <= s[ACC_WIDTH-1:0];
                end
            end
        end
    end

    // Select the element being dumped and multiply by alpha
    always_comb
    begin
        sel = acc_reg[cmd.row[IDX_WIDTH-1:0]][cmd.col[IDX_WIDTH-1:0]];
        prod_next = PW'(sel) * PW'(alpha);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale) prod_reg <= prod_next;
    end

    // Round half up, shift, saturate
    always_comb
    begin
        rnd = (prod_reg + PW'(128)) >>> ALPHA_SHIFT;
        if (rnd > OMAX) scaled = OMAX[OUT_WIDTH-1:0];
        else if (rnd < OMIN) scaled = OMIN[OUT_WIDTH-1:0];
        else scaled = rnd[OUT_WIDTH-1:0];
    end
endmodule
`default_nettype wire

/* design/gtm_ctrl.sv */
// Controller: accepts steps, sequences the row-major dump, drives output word.
// Depends on gtm_pkg.
`default_nettype none
module gtm_ctrl
    import gtm_pkg::*;
#(
    parameter int TILE_ROWS = 8,
    parameter int TILE_COLS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 in_last,
    input  wire logic [CNT_WIDTH-1:0] rows_cfg,
    input  wire logic [CNT_WIDTH-1:0] cols_cfg,
    output gtm_cmd_t                  cmd,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [IDX_WIDTH-1:0]      out_row,
    output logic [IDX_WIDTH-1:0]      out_col,
    output logic                      out_last
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] row_reg, row_next, col_reg, col_next;
    logic [3:0] nr, nc;
    logic in_fire, is_end;

    // Clamp the active tile size
    always_comb
    begin
        nr = (rows_cfg == 4'd0) ? 4'd1 : (rows_cfg > 4'(TILE_ROWS)) ? 4'(TILE_ROWS) : rows_cfg;
        nc = (cols_cfg == 4'd0) ? 4'd1 : (cols_cfg > 4'(TILE_COLS)) ? 4'(TILE_COLS) : cols_cfg;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign is_end   = (row_reg == nr - 4'd1) && (col_reg == nc - 4'd1);
    assign out_valid = (state_reg == S_OUT);
    assign out_row  = row_reg[IDX_WIDTH-1:0];
    assign out_col  = col_reg[IDX_WIDTH-1:0];
    assign out_last = is_end;

    always_comb
    begin
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        cmd = '0;
        cmd.row = row_reg;
        cmd.col = col_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accumulate = in_fire;
                row_next = '0;
                col_next = '0;
                if (in_fire && in_last) state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.scale = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (is_end)
                    begin
                        cmd.clear = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                        if (col_reg == nc - 4'd1)
                        begin
                            col_next = '0;
                            row_next = row_reg + 4'd1;
                        end
                        else col_next = col_reg + 4'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Hold the word while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_reg) && $stable(col_reg))
        else $error("dump word changed under stall");
    a_nointake: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !cmd.accumulate)
        else $error("step accepted during dump");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> out_valid && !out_stall && out_last)
        else $error("clear without final word");
endmodule
`default_nettype wire
